// File: hw/rtl/spdr_pkg.sv
// Shared types and constants of the spectral phase delay rotator.
// No dependencies; imported by spdr_qsine and spectral_phase_delay_rotator.
`default_nettype none

package spdr_pkg;

   // Defaults for the top-level parameters
   localparam int FFT_SIZE_DEF = 1024;
   localparam int NUM_BINS_DEF = 513;

   // Field widths
   localparam int SAMPLE_W = 24;
   localparam int ANGLE_W  = 16;
   localparam int DELAY_W  = 16;
   localparam int DELAY_FRAC = 8;
   localparam int IDX_W    = 10;
   localparam int CSR_W    = 16;

   // Quarter-wave sine: argument 0..16384, result unsigned Q.23
   localparam int REF_W  = 15;
   localparam int SINE_W = 23;
   localparam logic [REF_W-1:0]   QUARTER_TURN = 15'd16384;
   localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'h8000;
   localparam logic [SINE_W-1:0]  SINE_MAX     = 23'h7FFFFF;

   // Horner coefficients of the sine polynomial, unsigned Q30
   localparam logic [30:0] POLY_C1 = 31'd1686629713;
   localparam logic [29:0] POLY_C3 = 30'd693598668;
   localparam logic [26:0] POLY_C5 = 27'd85569306;
   localparam logic [22:0] POLY_C7 = 23'd5026995;
   localparam logic [17:0] POLY_C9 = 18'd172272;

   // Pipeline layout: input, phase, sine lane stages, products, output
   localparam int LANE_FIRST  = 2;
   localparam int LANE_STAGES = 6;
   localparam int PIPE_STAGES = LANE_FIRST + LANE_STAGES + 2;

   // Opcodes
   localparam logic OP_BIN   = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_DELAY    = 2'd0;
   localparam csr_index_type CSR_POLARITY = 2'd1;
   localparam csr_index_type CSR_TIME_ON  = 2'd2;
   localparam csr_index_type CSR_PHASE_ON = 2'd3;

   // Quadrant of a 16-bit phase
   typedef logic [1:0] quad_type;
   localparam quad_type QUAD_0 = 2'd0;
   localparam quad_type QUAD_1 = 2'd1;
   localparam quad_type QUAD_2 = 2'd2;
   localparam quad_type QUAD_3 = 2'd3;

   // Sideband that travels with each bin through the pipeline
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       last;
      logic                       active;
      quad_type                   quad;
   } side_type;

endpackage

`default_nettype wire

// File: hw/rtl/spdr_qsine.sv
// Pipelined quarter-wave sine: Horner polynomial over six stages.
// Depends on spdr_pkg for widths and coefficients.
`default_nettype none

module spdr_qsine (
   input  logic                              clock,
   input  logic [spdr_pkg::LANE_STAGES-1:0]  stage_en,
   input  logic [spdr_pkg::REF_W-1:0]        ref_arg,
   output logic [spdr_pkg::SINE_W-1:0]       sine
);
   import spdr_pkg::*;

   logic [REF_W-1:0]  r_ff [LANE_STAGES-1];
   logic [30:0]       x2_ff [LANE_STAGES-2];
   logic [22:0]       t1_ff;
   logic [26:0]       t2_ff;
   logic [29:0]       t3_ff;
   logic [30:0]       t4_ff;
   logic [SINE_W-1:0] sine_ff;

   logic [29:0]       rsq;
   logic [30:0]       x2_in;
   logic [48:0]       m1;
   logic [53:0]       m2;
   logic [57:0]       m3;
   logic [60:0]       m4;
   logic [45:0]       m5;
   logic [22:0]       t1_in;
   logic [26:0]       t2_in;
   logic [29:0]       t3_in;
   logic [30:0]       t4_in;
   logic [32:0]       rnd;
   logic [25:0]       vq;
   logic [SINE_W-1:0] sine_in;

   // x = r<<16, so (x*x)>>30 is exactly r*r*4
   assign rsq   = ref_arg * ref_arg;
   assign x2_in = {rsq[28:0], 2'b00};

   assign m1    = x2_ff[0] * POLY_C9;
   assign t1_in = POLY_C7 - 23'(m1[48:30]);
   assign m2    = x2_ff[1] * t1_ff;
   assign t2_in = POLY_C5 - 27'(m2[53:30]);
   assign m3    = x2_ff[2] * t2_ff;
   assign t3_in = POLY_C3 - 30'(m3[57:30]);
   assign m4    = x2_ff[3] * t3_ff;
   assign t4_in = POLY_C1 - m4[60:30];

   // (x*t)>>30 with x = r<<16 is (r*t)>>14; then round to Q.23 and cap
   assign m5      = r_ff[4] * t4_ff;
   assign rnd     = {1'b0, m5[45:14]} + 33'd64;
   assign vq      = rnd[32:7];
   assign sine_in = (vq > 26'(SINE_MAX)) ? SINE_MAX : vq[SINE_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         r_ff[0]  <= ref_arg;
         x2_ff[0] <= x2_in;
      end
      if (stage_en[1]) begin
         r_ff[1]  <= r_ff[0];
         x2_ff[1] <= x2_ff[0];
         t1_ff    <= t1_in;
      end
      if (stage_en[2]) begin
         r_ff[2]  <= r_ff[1];
         x2_ff[2] <= x2_ff[1];
         t2_ff    <= t2_in;
      end
      if (stage_en[3]) begin
         r_ff[3]  <= r_ff[2];
         x2_ff[3] <= x2_ff[2];
         t3_ff    <= t3_in;
      end
      if (stage_en[4]) begin
         r_ff[4] <= r_ff[3];
         t4_ff   <= t4_in;
      end
      if (stage_en[5]) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

// File: hw/rtl/spectral_phase_delay_rotator.sv
// Top level: per-bin delay and phase-table rotation of a stream of FFT bins.
// Depends on spdr_pkg and spdr_qsine (two instances: the angle and its complement).
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------------------------
//   req     | req_valid/req_stall, opcode, bin,  | in: bins and table writes
//           | frame_last, table_index/angle      |
//   rsp     | rsp_valid/rsp_stall, out_re/im/last| out: one transaction per bin
//   csr     | csr_we, csr_index, csr_wdata       | in: register writes
//
// One transaction per clock while rsp is not stalled; a bin's result is offered
// through ten register stages (input, phase, six sine stages, products, output).
// Each stage has its own valid bit, so bubbles close up while rsp is stalled.
// After reset the phase table is cleared one entry per cycle: req_stall stays
// high until every entry is cleared. Table writes produce no rsp transaction.
`default_nettype none

module spectral_phase_delay_rotator #(
   parameter int FFT_SIZE = spdr_pkg::FFT_SIZE_DEF,
   parameter int NUM_BINS = spdr_pkg::NUM_BINS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic signed [spdr_pkg::SAMPLE_W-1:0]  req_bin_re,
   input  logic signed [spdr_pkg::SAMPLE_W-1:0]  req_bin_im,
   input  logic                                  req_frame_last,
   input  logic [spdr_pkg::IDX_W-1:0]            req_table_index,
   input  logic signed [spdr_pkg::ANGLE_W-1:0]   req_table_angle,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [spdr_pkg::SAMPLE_W-1:0]  rsp_out_re,
   output logic signed [spdr_pkg::SAMPLE_W-1:0]  rsp_out_im,
   output logic                                  rsp_out_last,

   input  logic                                  csr_we,
   input  spdr_pkg::csr_index_type               csr_index,
   input  logic [spdr_pkg::CSR_W-1:0]            csr_wdata
);
   import spdr_pkg::*;

   // FFT_SIZE is a power of two: the division by it is an arithmetic shift
   localparam int FFT_LOG2 = $clog2(FFT_SIZE);
   localparam int KW       = $clog2(NUM_BINS + 1);
   localparam int AW       = $clog2(NUM_BINS);
   localparam int PW       = KW + DELAY_W + 1;
   localparam int PHASE_SH = ANGLE_W - DELAY_FRAC;
   localparam int ST_MUL   = LANE_FIRST + LANE_STAGES;
   localparam int ST_OUT   = ST_MUL + 1;
   localparam int ACC_W    = 2 * SAMPLE_W + 1;
   localparam int PROD_W   = 2 * SAMPLE_W;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SAMPLE_W - 2);
   localparam logic signed [ACC_W-1:0] Q_MAX_EXT  = (ACC_W'(1) << (SAMPLE_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] Q_MIN_EXT  = -Q_MAX_EXT - ACC_W'(1);

   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] sh;
      sh = (acc + ROUND_HALF) >>> (SAMPLE_W - 1);
      if (sh > Q_MAX_EXT) begin
         return Q_MAX_EXT[SAMPLE_W-1:0];
      end else if (sh < Q_MIN_EXT) begin
         return Q_MIN_EXT[SAMPLE_W-1:0];
      end
      return sh[SAMPLE_W-1:0];
   endfunction

   // ---------------------------------------------------------------- registers
   logic signed [DELAY_W-1:0] csr_delay_ff, csr_delay_in;
   logic                      csr_pol_ff, csr_pol_in;
   logic                      csr_time_ff, csr_time_in;
   logic                      csr_phase_ff, csr_phase_in;

   logic [KW-1:0]             bin_count_ff, bin_count_in;
   logic                      clr_busy_ff, clr_busy_in;
   logic [AW-1:0]             clr_cnt_ff, clr_cnt_in;

   logic [ANGLE_W-1:0]        tbl_mem [NUM_BINS];
   logic [ANGLE_W-1:0]        tbl_rd_ff;

   logic [PIPE_STAGES-1:0]    v_ff, v_in;
   logic [PIPE_STAGES-1:0]    en;
   side_type                  side_ff [ST_MUL+1];
   side_type                  side0_in, side1_in;
   logic signed [PW-1:0]      dprod_ff, dprod_in;
   logic [REF_W-2:0]          rot_r_ff, rot_r_in;

   logic signed [PROD_W-1:0]  p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;
   logic signed [PROD_W-1:0]  p_rc_in, p_is_in, p_rs_in, p_ic_in;
   logic signed [SAMPLE_W-1:0] rsp_re_ff, rsp_re_in;
   logic signed [SAMPLE_W-1:0] rsp_im_ff, rsp_im_in;
   logic                      rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- control
   logic                      req_acc, bin_acc, tw_acc;
   logic [31:0]               tw_idx;
   logic [AW-1:0]             tw_addr, tbl_rd_addr;
   logic [ANGLE_W-1:0]        tw_data;
   logic                      k_in_range;

   logic signed [PW+PHASE_SH-1:0] dsh, dsh_sr;
   logic [ANGLE_W-1:0]        dph, phase_in;

   logic [REF_W-1:0]          ref_a, ref_b;
   logic [SINE_W-1:0]         sine_a, sine_b;
   logic signed [SAMPLE_W-1:0] sa, sb, sin_v, cos_v;

   // Stage advance: a stage moves when it is empty or its successor moves
   always_comb begin
      en[ST_OUT] = !v_ff[ST_OUT] || !rsp_stall;
      for (int i = ST_OUT - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_stall = clr_busy_ff || !en[0];
   assign req_acc   = req_valid && !req_stall;
   assign bin_acc   = req_acc && (req_opcode == OP_BIN);

   assign tw_idx  = 32'(req_table_index);
   assign tw_acc  = req_acc && (req_opcode == OP_WRITE) && (tw_idx < 32'(NUM_BINS));
   assign tw_addr = tw_idx[AW-1:0];
   assign tw_data = ANGLE_W'(ANGLE_W'(0) - req_table_angle);

   always_comb begin
      v_in[0] = en[0] ? bin_acc : v_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   // Register writes
   always_comb begin
      csr_delay_in = csr_delay_ff;
      csr_pol_in   = csr_pol_ff;
      csr_time_in  = csr_time_ff;
      csr_phase_in = csr_phase_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY:    csr_delay_in = $signed(csr_wdata[DELAY_W-1:0]);
            CSR_POLARITY: csr_pol_in   = csr_wdata[0];
            CSR_TIME_ON:  csr_time_in  = csr_wdata[0];
            CSR_PHASE_ON: csr_phase_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Bin counter saturates at NUM_BINS; frame_last restarts it
   assign k_in_range  = 32'(bin_count_ff) < 32'(NUM_BINS);
   assign tbl_rd_addr = k_in_range ? bin_count_ff[AW-1:0] : '0;

   always_comb begin
      bin_count_in = bin_count_ff;
      if (bin_acc) begin
         if (req_frame_last) begin
            bin_count_in = '0;
         end else if (k_in_range) begin
            bin_count_in = bin_count_ff + KW'(1);
         end
      end
   end

   assign clr_busy_in = clr_busy_ff && (clr_cnt_ff != AW'(NUM_BINS - 1));
   assign clr_cnt_in  = clr_busy_ff ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_delay_ff <= '0;
         csr_pol_ff   <= 1'b0;
         csr_time_ff  <= 1'b0;
         csr_phase_ff <= 1'b0;
         bin_count_ff <= '0;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         v_ff         <= '0;
      end else begin
         csr_delay_ff <= csr_delay_in;
         csr_pol_ff   <= csr_pol_in;
         csr_time_ff  <= csr_time_in;
         csr_phase_ff <= csr_phase_in;
         bin_count_ff <= bin_count_in;
         clr_busy_ff  <= clr_busy_in;
         clr_cnt_ff   <= clr_cnt_in;
         v_ff         <= v_in;
      end
   end

   // Phase table: clear sweep after reset, then write transactions; read at bin accept
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         tbl_mem[clr_cnt_ff] <= '0;
      end else if (tw_acc) begin
         tbl_mem[tw_addr] <= tw_data;
      end
      if (bin_acc) begin
         tbl_rd_ff <= tbl_mem[tbl_rd_addr];
      end
   end

   // ---------------------------------------------------------------- stage 0
   always_comb begin
      side0_in.re     = req_bin_re;
      side0_in.im     = req_bin_im;
      side0_in.last   = req_frame_last;
      side0_in.active = k_in_range && (csr_time_ff || csr_phase_ff);
      side0_in.quad   = QUAD_0;
   end

   assign dprod_in = PW'($signed({1'b0, bin_count_ff})) * PW'(csr_delay_ff);

   // ---------------------------------------------------------------- stage 1
   // floor(k * delay * 256 / FFT_SIZE) mod 65536
   assign dsh    = $signed({dprod_ff, {PHASE_SH{1'b0}}});
   assign dsh_sr = dsh >>> FFT_LOG2;
   assign dph    = dsh_sr[ANGLE_W-1:0];

   always_comb begin
      phase_in = '0;
      if (csr_time_ff) begin
         phase_in = dph + (csr_pol_ff ? HALF_TURN : '0);
      end
      if (csr_phase_ff) begin
         phase_in = phase_in + tbl_rd_ff;
      end
      rot_r_in      = phase_in[REF_W-2:0];
      side1_in      = side_ff[0];
      side1_in.quad = phase_in[ANGLE_W-1 -: 2];
   end

   // ---------------------------------------------------------------- sine lanes
   assign ref_a = {1'b0, rot_r_ff};
   assign ref_b = QUARTER_TURN - ref_a;

   spdr_qsine u_sine_a (
      .clock    (clock),
      .stage_en (en[LANE_FIRST +: LANE_STAGES]),
      .ref_arg  (ref_a),
      .sine     (sine_a)
   );

   spdr_qsine u_sine_b (
      .clock    (clock),
      .stage_en (en[LANE_FIRST +: LANE_STAGES]),
      .ref_arg  (ref_b),
      .sine     (sine_b)
   );

   // ---------------------------------------------------------------- products
   assign sa = $signed({1'b0, sine_a});
   assign sb = $signed({1'b0, sine_b});

   always_comb begin
      case (side_ff[ST_MUL-1].quad)
         QUAD_0: begin
            sin_v = sa;
            cos_v = sb;
         end
         QUAD_1: begin
            sin_v = sb;
            cos_v = -sa;
         end
         QUAD_2: begin
            sin_v = -sa;
            cos_v = -sb;
         end
         default: begin
            sin_v = -sb;
            cos_v = sa;
         end
      endcase
   end

   assign p_rc_in = PROD_W'(side_ff[ST_MUL-1].re) * PROD_W'(cos_v);
   assign p_is_in = PROD_W'(side_ff[ST_MUL-1].im) * PROD_W'(sin_v);
   assign p_rs_in = PROD_W'(side_ff[ST_MUL-1].re) * PROD_W'(sin_v);
   assign p_ic_in = PROD_W'(side_ff[ST_MUL-1].im) * PROD_W'(cos_v);

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_last_in = side_ff[ST_MUL].last;
      if (side_ff[ST_MUL].active) begin
         rsp_re_in = round_sat(ACC_W'(p_rc_ff) - ACC_W'(p_is_ff));
         rsp_im_in = round_sat(ACC_W'(p_rs_ff) + ACC_W'(p_ic_ff));
      end else begin
         rsp_re_in = side_ff[ST_MUL].re;
         rsp_im_in = side_ff[ST_MUL].im;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side0_in;
         dprod_ff   <= dprod_in;
      end
      if (en[1]) begin
         side_ff[1] <= side1_in;
         rot_r_ff   <= rot_r_in;
      end
      for (int i = 2; i <= ST_MUL; i++) begin
         if (en[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
      if (en[ST_MUL]) begin
         p_rc_ff <= p_rc_in;
         p_is_ff <= p_is_in;
         p_rs_ff <= p_rs_in;
         p_ic_ff <= p_ic_in;
      end
      if (en[ST_OUT]) begin
         rsp_re_ff   <= rsp_re_in;
         rsp_im_ff   <= rsp_im_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = v_ff[ST_OUT];
   assign rsp_out_re   = rsp_re_ff;
   assign rsp_out_im   = rsp_im_ff;
   assign rsp_out_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_bin_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bin_count_ff) <= 32'(NUM_BINS))
      else $error("bin counter ran past NUM_BINS");

   a_clear_length: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_cnt_ff) == AW'(NUM_BINS - 1))
      else $error("table clear ended before the last entry");

   a_table_read_held: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && !en[0]) |=> $stable(tbl_rd_ff))
      else $error("table read data changed under a held bin");
`endif

endmodule

`default_nettype wire
